// ----- rtl/core/gcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// gcbp_pkg
// Shared types and constants of the gshare confidence branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package gcbp_pkg;

   // request opcodes
   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_CONFIDENCE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_CONFIDENCE_HALF  = 2'd1;
   localparam logic [1:0] CSR_STREAK_THRESHOLD = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;
   localparam int ADDRESS_BITS   = 64;
   localparam int ENTRY_BITS     = 3;
   localparam int CONF_BITS      = 4;
   localparam int RUN_BITS       = 5;

   localparam logic [CONF_BITS-1:0] LIMIT_RESET     = 4'd10;
   localparam logic [CONF_BITS-1:0] HALF_RESET      = 4'd5;
   localparam logic [CONF_BITS-1:0] THRESHOLD_RESET = 4'd15;

   // counter entry levels
   localparam logic [ENTRY_BITS-1:0] ENTRY_RESET       = 3'd4;
   localparam logic [ENTRY_BITS-1:0] ENTRY_MAX         = 3'd7;
   localparam logic [ENTRY_BITS-1:0] ENTRY_STRONG_T    = 3'd6;
   localparam logic [ENTRY_BITS-1:0] ENTRY_WEAK_T      = 3'd4;
   localparam logic [ENTRY_BITS-1:0] ENTRY_WEAK_NT     = 3'd2;

   typedef struct packed {
      logic clear_wr;  // write reset value during the clearing sweep
      logic accept;    // request beat taken this cycle
      logic exec;      // table entry is valid, decide or update
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep is at the last entry
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/gcbp_ram.sv -----
// ----------------------------------------------------------------------------
// gcbp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gcbp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gcbp_datapath.sv -----
// ----------------------------------------------------------------------------
// gcbp_datapath
// Index hash, counter table, confidence and run counters, decision and update.
// ----------------------------------------------------------------------------
`default_nettype none

module gcbp_datapath
   import gcbp_pkg::*;
#(
   parameter int HISTORY_BITS  = 14,
   parameter int TABLE_ENTRIES = 16384
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctrl_cmd_type              cmd,
   output dp_status_type                  status,
   input  wire logic                      csr_valid,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                      req_opcode,
   input  wire logic [ADDRESS_BITS-1:0]   req_branch_address,
   input  wire logic                      req_outcome_taken,
   output logic                           rsp_valid,
   output logic                           rsp_predict_taken
);

   localparam int INDEX_BITS = $clog2(TABLE_ENTRIES);

   logic [CONF_BITS-1:0]    limit_ff, half_ff, thr_ff;
   logic [HISTORY_BITS-1:0] history_ff;
   logic                    last_pred_ff, last_out_ff;
   logic [CONF_BITS-1:0]    tconf_ff, ntconf_ff;
   logic signed [RUN_BITS-1:0] run_ff;
   logic                    op_ff, taken_ff;
   logic [INDEX_BITS-1:0]   index_ff, clear_addr_ff;
   logic                    rsp_valid_ff, rsp_taken_ff;

   logic [CONF_BITS-1:0]    tconf_in, ntconf_in;
   logic signed [RUN_BITS-1:0] run_in;
   logic [ENTRY_BITS-1:0]   entry_in;
   logic                    pred;

   logic [ADDRESS_BITS-1:0] folded;
   logic [INDEX_BITS-1:0]   index_comb;
   logic [ENTRY_BITS-1:0]   entry;
   logic signed [RUN_BITS-1:0] thr_pos, thr_neg;

   logic                    ram_we;
   logic [INDEX_BITS-1:0]   ram_waddr;
   logic [ENTRY_BITS-1:0]   ram_wdata;

   // xor fold of address and history, low bits pick the entry
   assign folded = req_branch_address
                 ^ (req_branch_address >> HISTORY_BITS)
                 ^ (req_branch_address >> (2 * HISTORY_BITS))
                 ^ {{(ADDRESS_BITS - HISTORY_BITS){1'b0}}, history_ff};
   assign index_comb = folded[INDEX_BITS-1:0];

   assign ram_we    = cmd.clear_wr || (cmd.exec && op_ff == OP_RESOLVE);
   assign ram_waddr = cmd.clear_wr ? clear_addr_ff : index_ff;
   assign ram_wdata = cmd.clear_wr ? ENTRY_RESET : entry_in;

   gcbp_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (index_comb),
      .rd_data (entry)
   );

   assign status.clear_last = (clear_addr_ff == INDEX_BITS'(TABLE_ENTRIES - 1));

   assign thr_pos = $signed({1'b0, thr_ff});
   assign thr_neg = -thr_pos;

   always_comb begin
      if (run_ff == thr_pos) begin
         pred = 1'b1;
      end else if (run_ff == thr_neg) begin
         pred = 1'b0;
      end else if (entry >= ENTRY_STRONG_T) begin
         pred = 1'b1;
      end else if (entry >= ENTRY_WEAK_T) begin
         pred = (tconf_ff >= half_ff);
      end else if (entry >= ENTRY_WEAK_NT) begin
         pred = !(ntconf_ff >= half_ff);
      end else begin
         pred = 1'b0;
      end
   end

   always_comb begin
      run_in    = run_ff;
      tconf_in  = tconf_ff;
      ntconf_in = ntconf_ff;
      entry_in  = entry;

      if (run_ff < thr_pos && taken_ff) begin
         run_in = (last_out_ff == taken_ff) ? run_ff + 5'sd1 : '0;
      end else if (run_ff > thr_neg && !taken_ff) begin
         run_in = (last_out_ff == taken_ff) ? run_ff - 5'sd1 : '0;
      end

      if (taken_ff && last_pred_ff) begin
         if (tconf_ff < limit_ff) begin
            tconf_in = tconf_ff + 4'd1;
         end
         if (tconf_in == limit_ff && entry < ENTRY_MAX) begin
            entry_in = entry + 3'd1;
         end
      end else if (!taken_ff && !last_pred_ff) begin
         if (ntconf_ff < limit_ff) begin
            ntconf_in = ntconf_ff + 4'd1;
         end
         if (ntconf_in == limit_ff && entry > 3'd0) begin
            entry_in = entry - 3'd1;
         end
      end else if (!taken_ff) begin
         if (tconf_ff > 4'd0) begin
            tconf_in = tconf_ff - 4'd1;
         end
         if (entry > 3'd0) begin
            entry_in = entry - 3'd1;
         end
      end else begin
         if (ntconf_ff > 4'd0) begin
            ntconf_in = ntconf_ff - 4'd1;
         end
         if (entry < ENTRY_MAX) begin
            entry_in = entry + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         half_ff       <= HALF_RESET;
         thr_ff        <= THRESHOLD_RESET;
         history_ff    <= '0;
         last_pred_ff  <= 1'b0;
         last_out_ff   <= 1'b0;
         tconf_ff      <= '0;
         ntconf_ff     <= '0;
         run_ff        <= '0;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_CONFIDENCE_LIMIT: limit_ff <= csr_wdata;
               CSR_CONFIDENCE_HALF:  half_ff  <= csr_wdata;
               CSR_STREAK_THRESHOLD: thr_ff   <= csr_wdata;
               default: ;
            endcase
         end

         if (cmd.clear_wr) begin
            clear_addr_ff <= clear_addr_ff + INDEX_BITS'(1);
         end

         rsp_valid_ff <= cmd.exec && op_ff == OP_PREDICT;

         if (cmd.exec) begin
            if (op_ff == OP_PREDICT) begin
               last_pred_ff <= pred;
            end else begin
               run_ff      <= run_in;
               tconf_ff    <= tconf_in;
               ntconf_ff   <= ntconf_in;
               last_out_ff <= taken_ff;
               history_ff  <= {history_ff[HISTORY_BITS-2:0], taken_ff};
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_opcode;
         taken_ff <= req_outcome_taken;
         index_ff <= index_comb;
      end
      if (cmd.exec) begin
         rsp_taken_ff <= pred;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predict_taken = rsp_taken_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gcbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gcbp_ctrl
// Sequencer: table clearing sweep, request acceptance, decide/update step.
// ----------------------------------------------------------------------------
`default_nettype none

module gcbp_ctrl
   import gcbp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy         = busy_ff;
   assign cmd.clear_wr = (state_ff == ST_CLEAR);
   assign cmd.accept   = (state_ff == ST_IDLE) && start;
   assign cmd.exec     = (state_ff == ST_EXEC);

endmodule

`default_nettype wire

// ----- rtl/core/gshare_confidence_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// gshare_confidence_branch_predictor
// Gshare predictor with 3-bit counters, confidence counters and run detector.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken when start is high and busy is low. req_opcode
//   selects predict or resolve; the table index is the xor fold of
//   req_branch_address with the global history.
//   Each request reads the counter table in its accept cycle (registered
//   read port), then decides or writes the updated entry back in ST_EXEC.
//   busy is high in ST_EXEC, so no new request is taken before the last is done.
//   A predict beat gives one response: rsp_valid, registered from the ST_EXEC
//   step, pulses for one cycle with rsp_predict_taken. A resolve gives none.
//   The receiver has no backpressure; responses must be taken when shown.
//   The csr_ channel writes confidence_limit (0), confidence_half (1) and
//   streak_threshold (2); csr_ready is always high, other indexes are ignored.
//   After reset the table is swept to its reset value, one entry per cycle,
//   over every entry of the table with busy high; csr writes are taken meanwhile.
//   TABLE_ENTRIES must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module gshare_confidence_branch_predictor
   import gcbp_pkg::*;
#(
   parameter int HISTORY_BITS  = 14,
   parameter int TABLE_ENTRIES = 16384
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_opcode,
   input  wire logic [ADDRESS_BITS-1:0]   req_branch_address,
   input  wire logic                      req_outcome_taken,
   output logic                           rsp_valid,
   output logic                           rsp_predict_taken,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   gcbp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   gcbp_datapath #(
      .HISTORY_BITS  (HISTORY_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_opcode),
      .req_branch_address (req_branch_address),
      .req_outcome_taken  (req_outcome_taken),
      .rsp_valid          (rsp_valid),
      .rsp_predict_taken  (rsp_predict_taken)
   );

endmodule

`default_nettype wire
